// ===== hw/rtl/conv2d_3x3_valid_stream_assert.svh =====
// assertion macros shared by the conv2d 3x3 stream rtl
// no dependencies; included by the modules that carry checks
`ifndef CONV2D_3X3_VALID_STREAM_ASSERT_SVH
`define CONV2D_3X3_VALID_STREAM_ASSERT_SVH
`ifndef SYNTH
// check on the rising clock, off while reset is held
`define C2D3_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check on the rising clock, active during reset as well
`define C2D3_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C2D3_ASSERT(lbl, clk, rstn, prop, msg)
`define C2D3_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/c2d3_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the 3x3 convolution stream
// no dependencies
package c2d3_pkg;

    localparam int C2D3_MAX_WIDTH = 1024;
    localparam int KSIZE          = 3;
    localparam int WIN_START      = KSIZE - 1;

    localparam int PIX_W       = 8;
    localparam int COEF_W      = 16;
    localparam int COEF_ROW_W  = KSIZE * COEF_W;
    localparam int CFG_DATA_W  = COEF_ROW_W;
    localparam int CFG_INDEX_W = 3;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int ROW_W        = 12;
    localparam int MIN_DIM      = 3;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 1024;

    // product of signed q8.8 and unsigned pixel, then row and total sums
    localparam int PROD_W   = COEF_W + PIX_W + 1;
    localparam int ROWSUM_W = PROD_W + 2;
    localparam int CONV_W   = 28;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COEF_TOP     = 3'd0,
        CFG_COEF_MID     = 3'd1,
        CFG_COEF_BOTTOM  = 3'd2,
        CFG_IMAGE_WIDTH  = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4
    } cfg_index_t;

    typedef logic [COEF_ROW_W-1:0] coef_row_t;
    typedef coef_row_t [KSIZE-1:0] coef_set_t;

    // win[r][c]: r = 0 oldest row, c = 0 oldest column
    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic valid;
        logic frame_last;
    } tap_ctl_t;

    function automatic logic signed [COEF_W-1:0] coef_at(coef_row_t row, int unsigned b);
        return row[COEF_W*b +: COEF_W];
    endfunction

endpackage

// ===== hw/rtl/c2d3_linebuf.sv =====
`timescale 1ns / 1ps
// line memory, raster counters and 3x3 window for the convolution stream
// depends on c2d3_pkg and conv2d_3x3_valid_stream_assert.svh
`include "conv2d_3x3_valid_stream_assert.svh"

module c2d3_linebuf
    import c2d3_pkg::*;
#(
    parameter int MAX_WIDTH = C2D3_MAX_WIDTH,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_pixel,
    input  logic [AW-1:0]    w_last,
    input  logic [ROW_W-1:0] h_last,
    output tap_ctl_t         out_ctl,
    output win_t             out_win,
    input  logic             out_ready
);

    // one word per column: upper byte two rows up, lower byte one row up
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    logic               clr_busy_reg;
    logic [AW-1:0]      clr_addr_reg;

    logic [AW-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    logic               a_v_reg;
    logic [PIX_W-1:0]   a_px_reg;
    logic [AW-1:0]      a_col_reg;
    logic               a_prod_reg;
    logic               a_last_reg;

    win_t               win_reg, win_next;

    logic               accept;
    logic               a_adv;
    logic               a_free;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [2*PIX_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [PIX_W-1:0]   up1;
    logic [PIX_W-1:0]   up2;

    assign a_adv   = a_v_reg && (!a_prod_reg || out_ready);
    assign a_free  = !a_v_reg || a_adv;
    assign s_ready = !clr_busy_reg && a_free;
    assign accept  = s_valid && s_ready;

    assign up1 = rd_data_reg[PIX_W-1:0];
    assign up2 = rd_data_reg[2*PIX_W-1:PIX_W];

    // consecutive words never share a column (width is at least three),
    // so the write-back and the next read never hit the same entry
    assign rd_en   = accept;
    assign rd_addr = col_reg;
    assign wr_en   = clr_busy_reg || a_adv;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : a_col_reg;
    assign wr_data = clr_busy_reg ? '0 : {up1, a_px_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_reg >= w_last) begin
                col_next = '0;
                row_next = (row_reg >= h_last) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE - 1; c++) begin
                win_next[r][c] = win_reg[r][c+1];
            end
        end
        win_next[0][KSIZE-1] = up2;
        win_next[1][KSIZE-1] = up1;
        win_next[2][KSIZE-1] = a_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            a_v_reg      <= 1'b0;
            win_reg      <= '0;
        end else begin
            // clearing sweep through the line memory after reset
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_WIDTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (a_free) begin
                a_v_reg <= accept;
            end
            if (a_adv) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_px_reg   <= s_pixel;
            a_col_reg  <= col_reg;
            a_prod_reg <= (row_reg >= ROW_W'(WIN_START)) && (col_reg >= AW'(WIN_START));
            a_last_reg <= (row_reg == h_last) && (col_reg == w_last);
        end
    end

    assign out_ctl.valid      = a_v_reg && a_prod_reg;
    assign out_ctl.frame_last = a_last_reg;
    assign out_win            = win_next;

    `C2D3_ASSERT(a_rw_distinct, aclk, aresetn, (wr_en && rd_en) |-> (wr_addr != rd_addr), "line memory read and write hit one column")
    `C2D3_ASSERT(a_clear_blocks, aclk, aresetn, clr_busy_reg |-> !s_ready, "word taken during clear")
    `C2D3_ASSERT_NR(a_reset_clear, aclk, !aresetn |=> (clr_busy_reg && (clr_addr_reg == '0)), "clear not restarted by reset")
    `C2D3_ASSERT(a_stage_hold, aclk, aresetn, (a_v_reg && !a_adv) |=> (a_v_reg && $stable(a_col_reg) && $stable(win_reg)), "stalled stage lost its word")

endmodule

// ===== hw/rtl/c2d3_mac.sv =====
`timescale 1ns / 1ps
// nine products, row sums, final sum and output register
// depends on c2d3_pkg and conv2d_3x3_valid_stream_assert.svh
`include "conv2d_3x3_valid_stream_assert.svh"

module c2d3_mac
    import c2d3_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tap_ctl_t                 in_ctl,
    input  win_t                     in_win,
    output logic                     in_ready,
    input  coef_set_t                coef,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [CONV_W-1:0] m_conv_value,
    output logic                     m_frame_last
);

    logic signed [PROD_W-1:0]   prod_reg [KSIZE][KSIZE];
    logic signed [PROD_W-1:0]   prod_next [KSIZE][KSIZE];
    logic signed [ROWSUM_W-1:0] rsum_reg [KSIZE];
    logic signed [ROWSUM_W-1:0] rsum_next [KSIZE];
    logic signed [CONV_W-1:0]   conv_next;
    logic signed [CONV_W-1:0]   conv_reg;
    logic signed [PROD_W-1:0]   coef_ext [KSIZE][KSIZE];
    logic signed [PROD_W-1:0]   pix_ext [KSIZE][KSIZE];

    logic b_v_reg, b_last_reg;
    logic c_v_reg, c_last_reg;
    logic m_valid_reg, m_last_reg;
    logic o_free, c_free, b_free;

    assign o_free   = !m_valid_reg || m_ready;
    assign c_free   = !c_v_reg || o_free;
    assign b_free   = !b_v_reg || c_free;
    assign in_ready = b_free;

    // true convolution: kernel tap (a,b) meets window pixel (2-a,2-b)
    always_comb begin
        for (int a = 0; a < KSIZE; a++) begin
            for (int b = 0; b < KSIZE; b++) begin
                coef_ext[a][b]  = PROD_W'(coef_at(coef[a], b));
                pix_ext[a][b]   = PROD_W'($signed({1'b0, in_win[KSIZE-1-a][KSIZE-1-b]}));
                prod_next[a][b] = coef_ext[a][b] * pix_ext[a][b];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < KSIZE; a++) begin
            rsum_next[a] = ROWSUM_W'(prod_reg[a][0]) + ROWSUM_W'(prod_reg[a][1])
                         + ROWSUM_W'(prod_reg[a][2]);
        end
        conv_next = CONV_W'(rsum_reg[0]) + CONV_W'(rsum_reg[1]) + CONV_W'(rsum_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg     <= 1'b0;
            c_v_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (b_free) begin
                b_v_reg <= in_ctl.valid;
            end
            if (c_free) begin
                c_v_reg <= b_v_reg;
            end
            if (o_free) begin
                m_valid_reg <= c_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ctl.valid && b_free) begin
            prod_reg   <= prod_next;
            b_last_reg <= in_ctl.frame_last;
        end
        if (b_v_reg && c_free) begin
            rsum_reg   <= rsum_next;
            c_last_reg <= b_last_reg;
        end
        if (c_v_reg && o_free) begin
            conv_reg   <= conv_next;
            m_last_reg <= c_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_conv_value = conv_reg;
    assign m_frame_last = m_last_reg;

    `C2D3_ASSERT(a_sum_lands, aclk, aresetn, (c_v_reg && o_free) |=> m_valid_reg, "row sums did not reach the output")

endmodule

// ===== hw/rtl/conv2d_3x3_valid_stream.sv =====
`timescale 1ns / 1ps
// top of the 3x3 valid-region convolution stream: config registers, linebuf, mac
// depends on c2d3_pkg, c2d3_linebuf and c2d3_mac
//
// Takes one 8-bit pixel per clock in raster order while s_ready is high and returns
// one signed Q20.8 sum per pixel once two rows and two columns of the frame have
// arrived, so a W x H frame gives (W-2) x (H-2) words, the last one flagged by
// frame_last. Sustained rate is one pixel per cycle unless the output stalls;
// results pass the linebuf, product, row-sum and output registers. The line memory
// holds both previous rows in one word per column and does one read and one
// write-back per pixel, which sets that rate. After reset the block sweeps the line
// memory to zero with s_ready low; configuration writes are taken meanwhile.
// Registers: 0..2 kernel rows top to bottom (three signed Q8.8 taps, column 0
// in the low bits), 3 image width, 4 image height; write them only when idle.
module conv2d_3x3_valid_stream
    import c2d3_pkg::*;
#(
    parameter int MAX_WIDTH = C2D3_MAX_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIX_W-1:0]         s_pixel,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [CONV_W-1:0] m_conv_value,
    output logic                     m_frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int GW = (AW + 1 > WIDTH_REG_W) ? AW + 1 : WIDTH_REG_W;

    coef_row_t               coef_top_reg;
    coef_row_t               coef_mid_reg;
    coef_row_t               coef_bottom_reg;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    coef_set_t               coef;
    logic [GW-1:0]           width_ext;
    logic [GW-1:0]           width_use;
    logic [HEIGHT_REG_W-1:0] height_use;
    logic [AW-1:0]           w_last;
    logic [ROW_W-1:0]        h_last;
    tap_ctl_t                tap_ctl;
    win_t                    tap_win;
    logic                    tap_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg    <= '0;
            coef_mid_reg    <= '0;
            coef_bottom_reg <= '0;
            width_reg       <= WIDTH_REG_W'(WIDTH_RESET);
            height_reg      <= HEIGHT_REG_W'(HEIGHT_RESET);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_COEF_TOP: begin
                    coef_top_reg <= cfg_wdata;
                end
                CFG_COEF_MID: begin
                    coef_mid_reg <= cfg_wdata;
                end
                CFG_COEF_BOTTOM: begin
                    coef_bottom_reg <= cfg_wdata;
                end
                CFG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata[WIDTH_REG_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp the geometry into range and hand down the last index of each
    always_comb begin
        width_ext = GW'(width_reg);
        if (width_ext < GW'(MIN_DIM)) begin
            width_use = GW'(MIN_DIM);
        end else if (width_ext > GW'(MAX_WIDTH)) begin
            width_use = GW'(MAX_WIDTH);
        end else begin
            width_use = width_ext;
        end
        if (height_reg < HEIGHT_REG_W'(MIN_DIM)) begin
            height_use = HEIGHT_REG_W'(MIN_DIM);
        end else if (height_reg > HEIGHT_REG_W'(HEIGHT_LIMIT)) begin
            height_use = HEIGHT_REG_W'(HEIGHT_LIMIT);
        end else begin
            height_use = height_reg;
        end
        w_last = AW'(width_use - GW'(1));
        h_last = ROW_W'(height_use - HEIGHT_REG_W'(1));
    end

    always_comb begin
        coef[0] = coef_top_reg;
        coef[1] = coef_mid_reg;
        coef[2] = coef_bottom_reg;
    end

    c2d3_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_linebuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .w_last    (w_last),
        .h_last    (h_last),
        .out_ctl   (tap_ctl),
        .out_win   (tap_win),
        .out_ready (tap_ready)
    );

    c2d3_mac u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_ctl       (tap_ctl),
        .in_win       (tap_win),
        .in_ready     (tap_ready),
        .coef         (coef),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_conv_value (m_conv_value),
        .m_frame_last (m_frame_last)
    );

endmodule

// ===== sim/tb_conv2d_3x3_valid_stream.sv =====
`timescale 1ns / 1ps
// self-checking bench for conv2d_3x3_valid_stream: directed pixel table, then random phases
// depends on c2d3_pkg and the rtl under hw/rtl; results checked against an in-bench model
module tb_conv2d_3x3_valid_stream;
    import c2d3_pkg::*;

    localparam int RESULT_LATENCY    = 4;
    localparam int DRAIN_CYCLES      = 4 * RESULT_LATENCY;
    localparam int QUIET_LIMIT       = 5000;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS       = 40;
    localparam int RANDOM_ITEMS      = 1730;
    localparam int HOLD_PHASE_A      = 2;
    localparam int HOLD_PHASE_B      = 7;
    localparam int WIDE_PHASE        = 4;
    localparam int TALL_PHASE        = 6;
    localparam int WIDE_WIDTH        = C2D3_MAX_WIDTH / 2;
    localparam int RESET_GEOM_ROWS   = 3;
    localparam int DIRECTED_COUNT    = 19;
    localparam int FIRST_SPARE_INDEX = int'(CFG_IMAGE_HEIGHT) + 1;

    localparam logic [COEF_W-1:0] COEF_MOST_NEGATIVE = 16'h8000;
    localparam logic [COEF_W-1:0] COEF_MOST_POSITIVE = 16'h7FFF;
    localparam logic [COEF_W-1:0] COEF_UNITY         = 16'h0100;

    // white 3x3 patch under two rows of most negative taps and one of most positive
    localparam int MIXED_KERNEL_SUM = -6 * 255 * 32768 + 3 * 255 * 32767;

    typedef struct packed {
        logic signed [CONV_W-1:0] conv_value;
        logic                     frame_last;
    } conv_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             typed;
        logic             has_word;
        conv_word_t       word;
    } pixel_row_t;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_STALLED, SINK_TOGGLE} sink_mode_e;

    // rows 0..2 run at reset geometry; the rest after switching to a 3x3 frame
    localparam pixel_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'h00, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'h5A, 1'b1, 1'b0, '{'0, 1'b0}},
        // column counter sits past the new width: wraps, then a misaligned frame
        '{8'h01, 1'b0, 1'b0, '{'0, 1'b0}},
        '{8'h80, 1'b0, 1'b0, '{'0, 1'b0}},
        '{8'h7F, 1'b0, 1'b0, '{'0, 1'b0}},
        '{8'hFE, 1'b0, 1'b0, '{'0, 1'b0}},
        '{8'h00, 1'b0, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, '{'0, 1'b0}},
        '{8'h55, 1'b0, 1'b0, '{'0, 1'b0}},
        // clean frame of white pixels
        '{8'hFF, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, '{'0, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{CONV_W'(MIXED_KERNEL_SUM), 1'b1}}
    };

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic [PIX_W-1:0]         s_pixel;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [CONV_W-1:0] m_conv_value;
    logic                     m_frame_last;

    // model of the block
    logic [COEF_ROW_W-1:0]   kernel_rows [KSIZE] = '{default: '0};
    logic [WIDTH_REG_W-1:0]  width_setting  = WIDTH_REG_W'(WIDTH_RESET);
    logic [HEIGHT_REG_W-1:0] height_setting = HEIGHT_REG_W'(HEIGHT_RESET);
    logic [PIX_W-1:0]        line_prev  [C2D3_MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0]        line_prev2 [C2D3_MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0]        window_px  [KSIZE][KSIZE] = '{default: '{default: '0}};
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;

    conv_word_t pending_words [$];
    int         mismatch_count = 0;
    int         burst_left = 0;
    bit         long_hold_req = 1'b0;

    conv2d_3x3_valid_stream dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // one accepted pixel through line stores, window and counters
    function automatic void advance_convolution(input logic [PIX_W-1:0] px,
                                                output bit has_word, output conv_word_t word);
        int unsigned w;
        int unsigned h;
        logic [PIX_W-1:0] up1;
        logic [PIX_W-1:0] up2;
        logic signed [COEF_W-1:0] tap;
        int acc;
        w = clamp_dim(width_setting, MIN_DIM, C2D3_MAX_WIDTH);
        h = clamp_dim(height_setting, MIN_DIM, HEIGHT_LIMIT);
        up1 = line_prev[col_pos];
        up2 = line_prev2[col_pos];
        line_prev2[col_pos] = up1;
        line_prev[col_pos] = px;
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE - 1; c++) window_px[r][c] = window_px[r][c+1];
        end
        window_px[0][KSIZE-1] = up2;
        window_px[1][KSIZE-1] = up1;
        window_px[2][KSIZE-1] = px;
        has_word = (row_pos >= WIN_START && col_pos >= WIN_START);
        word = '0;
        if (has_word) begin
            acc = 0;
            // kernel is flipped against the window
            for (int a = 0; a < KSIZE; a++) begin
                for (int b = 0; b < KSIZE; b++) begin
                    tap = kernel_rows[a][COEF_W*b +: COEF_W];
                    acc += int'(tap) * int'(window_px[KSIZE-1-a][KSIZE-1-b]);
                end
            end
            word.conv_value = acc[CONV_W-1:0];
            word.frame_last = (row_pos == h - 1 && col_pos == w - 1);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_COEF_TOP, CFG_COEF_MID, CFG_COEF_BOTTOM: kernel_rows[idx] = val;
            CFG_IMAGE_WIDTH:  width_setting  = val[WIDTH_REG_W-1:0];
            CFG_IMAGE_HEIGHT: height_setting = val[HEIGHT_REG_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // sender side: bursts of random length with random gaps, sometimes none, between them
    task automatic feed_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input bit typed_has, input conv_word_t typed_word);
        int gap;
        bit has_word;
        conv_word_t word;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        advance_convolution(px, has_word, word);
        if (typed) begin
            has_word = typed_has;
            word = typed_word;
        end
        if (has_word) pending_words = {pending_words, word};
    endtask

    // stop sending and let every expected word and any trailing work drain
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_kernel_row();
        logic [CFG_DATA_W-1:0] r;
        r = '0;
        for (int b = 0; b < KSIZE; b++) begin
            case ($urandom_range(0, 9))
                0: r[COEF_W*b +: COEF_W] = COEF_MOST_NEGATIVE;
                1: r[COEF_W*b +: COEF_W] = COEF_MOST_POSITIVE;
                2: r[COEF_W*b +: COEF_W] = '0;
                3: r[COEF_W*b +: COEF_W] = COEF_UNITY;
                default: r[COEF_W*b +: COEF_W] = COEF_W'($urandom_range(0, 65535));
            endcase
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: open, random, stalled and toggling stretches, plus the long hold-off
    initial begin : result_sink
        int seg_left;
        int cyc;
        sink_mode_e seg_mode;
        m_ready = 1'b0;
        seg_left = 0;
        cyc = 0;
        seg_mode = SINK_OPEN;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end
            if (seg_left == 0) begin
                seg_mode = sink_mode_e'($urandom_range(0, 3));
                seg_left = (seg_mode == SINK_STALLED) ? $urandom_range(1, 8)
                                                      : $urandom_range(4, 60);
            end
            seg_left--;
            cyc++;
            case (seg_mode)
                SINK_OPEN:    m_ready <= 1'b1;
                SINK_RANDOM:  m_ready <= ($urandom_range(0, 2) != 0);
                SINK_STALLED: m_ready <= 1'b0;
                default:      m_ready <= (cyc % 2 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : word_check
        conv_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d last %b",
                                          m_conv_value, m_frame_last));
            end else begin
                want = pending_words.pop_front();
                if (m_conv_value !== want.conv_value)
                    report_mismatch($sformatf("conv_value %0d, want %0d",
                                              m_conv_value, want.conv_value));
                if (m_frame_last !== want.frame_last)
                    report_mismatch($sformatf("frame_last %b, want %b (conv_value %0d)",
                                              m_frame_last, want.frame_last, want.conv_value));
            end
        end
    end

    // ends the run when nothing has moved for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet = 0;
            else quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int i;
        int n;
        int area;
        int phase_no;
        int random_items;
        int w_pick;
        int h_pick;
        logic [CFG_DATA_W-1:0] cfg_val;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_pixel   = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: first three pixels of a 1024 x 1024 frame, nothing comes out
        for (i = 0; i < RESET_GEOM_ROWS; i++)
            feed_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].has_word, DIRECTED_ROWS[i].word);
        settle();
        write_reg(CFG_COEF_TOP, {KSIZE{COEF_MOST_NEGATIVE}});
        write_reg(CFG_COEF_MID, {KSIZE{COEF_MOST_NEGATIVE}});
        write_reg(CFG_COEF_BOTTOM, {KSIZE{COEF_MOST_POSITIVE}});
        // junk above the register width must be dropped: width 3, height 3
        write_reg(CFG_IMAGE_WIDTH, 48'hFFFF_FFFF_F803);
        write_reg(CFG_IMAGE_HEIGHT, 48'hABCD_E000_0003);
        for (i = FIRST_SPARE_INDEX; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), '1);
        for (i = RESET_GEOM_ROWS; i < DIRECTED_COUNT; i++)
            feed_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].has_word, DIRECTED_ROWS[i].word);

        phase_no = 0;
        random_items = 0;
        // every special phase runs before the item budget closes the loop
        while (random_items < RANDOM_ITEMS || phase_no <= HOLD_PHASE_B) begin
            settle();
            if ($urandom_range(0, 1) != 0) write_reg(CFG_COEF_TOP, pick_kernel_row());
            if ($urandom_range(0, 1) != 0) write_reg(CFG_COEF_MID, pick_kernel_row());
            if ($urandom_range(0, 1) != 0) write_reg(CFG_COEF_BOTTOM, pick_kernel_row());

            case ($urandom_range(0, 9))
                0: w_pick = $urandom_range(0, MIN_DIM - 1);
                1: w_pick = $urandom_range(C2D3_MAX_WIDTH + 1, (1 << WIDTH_REG_W) - 1);
                default: w_pick = $urandom_range(MIN_DIM, 12);
            endcase
            case ($urandom_range(0, 9))
                0: h_pick = $urandom_range(0, MIN_DIM - 1);
                1: h_pick = HEIGHT_LIMIT;
                2: h_pick = $urandom_range(HEIGHT_LIMIT + 1, (1 << HEIGHT_REG_W) - 1);
                default: h_pick = $urandom_range(MIN_DIM, 8);
            endcase
            if (phase_no == WIDE_PHASE) begin
                w_pick = WIDE_WIDTH;
                h_pick = MIN_DIM;
            end
            if (phase_no == TALL_PHASE) begin
                w_pick = MIN_DIM;
                h_pick = HEIGHT_LIMIT;
            end
            if ($urandom_range(0, 4) != 0 || phase_no == WIDE_PHASE || phase_no == TALL_PHASE) begin
                cfg_val = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
                cfg_val[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w_pick);
                write_reg(CFG_IMAGE_WIDTH, cfg_val);
            end
            if ($urandom_range(0, 4) != 0 || phase_no == WIDE_PHASE || phase_no == TALL_PHASE) begin
                cfg_val = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
                cfg_val[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'(h_pick);
                write_reg(CFG_IMAGE_HEIGHT, cfg_val);
            end

            area = clamp_dim(width_setting, MIN_DIM, C2D3_MAX_WIDTH)
                 * clamp_dim(height_setting, MIN_DIM, HEIGHT_LIMIT);
            if (phase_no == WIDE_PHASE)
                n = 2 * WIDE_WIDTH + 40;
            else if (area <= 96)
                n = area * $urandom_range(1, 3)
                  + (($urandom_range(0, 1) != 0) ? $urandom_range(0, area - 1) : 0);
            else
                n = $urandom_range(20, 70);
            // receiver sits idle while pixels keep coming, so the input backs up
            if (phase_no == HOLD_PHASE_A || phase_no == HOLD_PHASE_B) begin
                long_hold_req = 1'b1;
                if (n < 80) n = 80;
            end

            for (i = 0; i < n; i++) feed_pixel(pick_pixel(), 1'b0, 1'b0, '0);
            random_items += n;
            phase_no++;
        end

        settle();
        if (mismatch_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
